/* hdl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int TIME_W   = 64;
	localparam int TAG_W    = 8;
	localparam int SECS_W   = 16;
	localparam int TPS_W    = 32;
	localparam int PROD_W   = SECS_W + TPS_W;

	localparam logic [TPS_W-1:0]  TPS_RESET = 32'd10000000;
	localparam logic [TIME_W-1:0] NO_EVENT  = {TIME_W{1'b1}};

	localparam logic ACT_ADD     = 1'b0;
	localparam logic ACT_SERVICE = 1'b1;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_EARLY,
		KIND_FULL,
		KIND_EXPIRED
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_INS,
		ST_SVC
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic              insert;
		logic              pop;
		logic [TIME_W-1:0] deadline;
		logic [TAG_W-1:0]  tag;
	} chain_cmd_t;

	typedef struct packed {
		entry_t first;
		entry_t second;
		logic   full;
	} head_t;

endpackage

/* hdl/sorted_timer_event_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Deadline-sorted timer event queue built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// usage
//   input transaction: start high while busy is low; action, now_time,
//   delay_seconds and event_tag are sampled at that edge
//   add (action 0): deadline = now_time + delay_seconds * ticks_per_second,
//   computed in the states ST_MUL (multiply), ST_ADD (add) and ST_INS (chain insert);
//   the single result shows once ST_INS is left, busy drops in that same
//   cycle, so a new add is taken only once the last one has its result
//   service (action 1): one expired result per cycle, then a final result
//   with last_result high
//   every cell compares against the new deadline in the same cycle, so an
//   insert does not take longer at a larger DEPTH
//   results: done high for exactly one cycle per result transaction; the
//   receiver cannot stall, the result port is a register
//   config: cfg_we writes ticks_per_second; the user writes it only while
//   busy is low and no result is outstanding, the block does not enforce this
//   reset: queue empty, ticks_per_second = 10000000
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [stq_pkg::TIME_W-1:0]  now_time,
	input  logic [stq_pkg::SECS_W-1:0]  delay_seconds,
	input  logic [stq_pkg::TAG_W-1:0]   event_tag,
	input  logic                        cfg_we,
	input  logic [stq_pkg::TPS_W-1:0]   cfg_wdata,
	output logic                        done,
	output logic [1:0]                  result_kind,
	output logic [stq_pkg::TAG_W-1:0]   expired_tag,
	output logic [stq_pkg::TIME_W-1:0]  next_compare,
	output logic                        last_result
);

	stq_pkg::chain_cmd_t cmd;
	stq_pkg::head_t      head;
	stq_pkg::entry_t     entries [DEPTH];
	logic                takes   [DEPTH];

	stq_pkg::entry_t     empty_entry;

	assign empty_entry.valid    = 1'b0;
	assign empty_entry.deadline = stq_pkg::NO_EVENT;
	assign empty_entry.tag      = '0;

	assign head.first  = entries[0];
	assign head.second = entries[1];
	assign head.full   = entries[DEPTH-1].valid;

	stq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.now_time      (now_time),
		.delay_seconds (delay_seconds),
		.event_tag     (event_tag),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.head          (head),
		.cmd           (cmd),
		.done          (done),
		.result_kind   (result_kind),
		.expired_tag   (expired_tag),
		.next_compare  (next_compare),
		.last_result   (last_result)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stq_pkg::entry_t prev_e;
		stq_pkg::entry_t next_e;
		logic            prev_t;

		if (i == 0) begin : g_first
			assign prev_e = empty_entry;
			assign prev_t = 1'b0;
		end else begin : g_mid
			assign prev_e = entries[i-1];
			assign prev_t = takes[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = empty_entry;
		end else begin : g_inner
			assign next_e = entries[i+1];
		end

		stq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev_e),
			.prev_take  (prev_t),
			.next_entry (next_e),
			.entry      (entries[i]),
			.take       (takes[i])
		);
	end

endmodule

/* hdl/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds an event, takes the new event or its
// left neighbor on insert, takes its right neighbor on pop.
// ----------------------------------------------------------------------------
module stq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::chain_cmd_t cmd,
	input  stq_pkg::entry_t    prev_entry,
	input  logic               prev_take,
	input  stq_pkg::entry_t    next_entry,
	output stq_pkg::entry_t    entry,
	output logic               take
);

	logic                      valid_q;
	logic [stq_pkg::TIME_W-1:0] deadline_q;
	logic [stq_pkg::TAG_W-1:0]  tag_q;

	// slot is empty or holds a later deadline than the new event
	assign take = !valid_q || (deadline_q > cmd.deadline);

	assign entry.valid    = valid_q;
	assign entry.deadline = deadline_q;
	assign entry.tag      = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_entry.valid;
		end else if (cmd.insert && take) begin
			valid_q <= prev_take ? prev_entry.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			deadline_q <= next_entry.deadline;
			tag_q      <= next_entry.tag;
		end else if (cmd.insert && take) begin
			if (prev_take) begin
				deadline_q <= prev_entry.deadline;
				tag_q      <= prev_entry.tag;
			end else begin
				deadline_q <= cmd.deadline;
				tag_q      <= cmd.tag;
			end
		end
	end

endmodule

/* hdl/stq_ctrl.sv */
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer of the queue: deadline arithmetic, insert and pop commands to the
// chain, and the registered result port.
// ----------------------------------------------------------------------------
module stq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [stq_pkg::TIME_W-1:0]  now_time,
	input  logic [stq_pkg::SECS_W-1:0]  delay_seconds,
	input  logic [stq_pkg::TAG_W-1:0]   event_tag,
	input  logic                        cfg_we,
	input  logic [stq_pkg::TPS_W-1:0]   cfg_wdata,
	input  stq_pkg::head_t              head,
	output stq_pkg::chain_cmd_t         cmd,
	output logic                        done,
	output logic [1:0]                  result_kind,
	output logic [stq_pkg::TAG_W-1:0]   expired_tag,
	output logic [stq_pkg::TIME_W-1:0]  next_compare,
	output logic                        last_result
);

	stq_pkg::state_t state_q, state_d;

	logic [stq_pkg::TPS_W-1:0]  tps_q;
	logic [stq_pkg::TIME_W-1:0] now_q;
	logic [stq_pkg::SECS_W-1:0] secs_q;
	logic [stq_pkg::TAG_W-1:0]  tag_q;
	logic [stq_pkg::PROD_W-1:0] prod_q;
	logic [stq_pkg::TIME_W-1:0] dl_q;

	logic                       expire;
	logic                       res_we;
	stq_pkg::kind_t             res_kind;
	logic [stq_pkg::TAG_W-1:0]  res_tag;
	logic [stq_pkg::TIME_W-1:0] res_cmp;
	logic                       res_last;

	logic                       done_q;
	stq_pkg::kind_t             kind_q;
	logic [stq_pkg::TAG_W-1:0]  exp_tag_q;
	logic [stq_pkg::TIME_W-1:0] cmp_q;
	logic                       last_q;

	assign expire = head.first.valid && (head.first.deadline <= now_q);
	assign busy   = (state_q != stq_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stq_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (action == stq_pkg::ACT_SERVICE) ? stq_pkg::ST_SVC
						: stq_pkg::ST_MUL;
				end
			end
			stq_pkg::ST_MUL: state_d = stq_pkg::ST_ADD;
			stq_pkg::ST_ADD: state_d = stq_pkg::ST_INS;
			stq_pkg::ST_INS: state_d = stq_pkg::ST_IDLE;
			stq_pkg::ST_SVC: state_d = expire ? stq_pkg::ST_SVC : stq_pkg::ST_IDLE;
			default:         state_d = stq_pkg::ST_IDLE;
		endcase
	end

	// chain commands and result
	always_comb begin
		cmd.insert   = 1'b0;
		cmd.pop      = 1'b0;
		cmd.deadline = dl_q;
		cmd.tag      = tag_q;
		res_we       = 1'b0;
		res_kind     = stq_pkg::KIND_ADD;
		res_tag      = '0;
		res_cmp      = stq_pkg::NO_EVENT;
		res_last     = 1'b0;
		unique case (state_q)
			stq_pkg::ST_INS: begin
				res_we   = 1'b1;
				res_last = 1'b1;
				if (head.full) begin
					res_kind = stq_pkg::KIND_FULL;
					res_cmp  = head.first.deadline;
				end else begin
					cmd.insert = 1'b1;
					if (!head.first.valid || (dl_q < head.first.deadline)) begin
						res_kind = stq_pkg::KIND_EARLY;
						res_cmp  = dl_q;
					end else begin
						res_cmp  = head.first.deadline;
					end
				end
			end
			stq_pkg::ST_SVC: begin
				res_we = 1'b1;
				if (expire) begin
					cmd.pop  = 1'b1;
					res_kind = stq_pkg::KIND_EXPIRED;
					res_tag  = head.first.tag;
					res_cmp  = head.second.valid ? head.second.deadline
						: stq_pkg::NO_EVENT;
				end else begin
					res_last = 1'b1;
					res_cmp  = head.first.valid ? head.first.deadline
						: stq_pkg::NO_EVENT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
			tps_q   <= stq_pkg::TPS_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_we;
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			now_q  <= now_time;
			secs_q <= delay_seconds;
			tag_q  <= event_tag;
		end
		prod_q <= stq_pkg::PROD_W'(secs_q) * stq_pkg::PROD_W'(tps_q);
		dl_q   <= now_q + stq_pkg::TIME_W'(prod_q);
		if (res_we) begin
			kind_q    <= res_kind;
			exp_tag_q <= res_tag;
			cmp_q     <= res_cmp;
			last_q    <= res_last;
		end
	end

	assign done         = done_q;
	assign result_kind  = kind_q;
	assign expired_tag  = exp_tag_q;
	assign next_compare = cmp_q;
	assign last_result  = last_q;

endmodule

/* hdl/stq_checker.sv */
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  result_kind,
	input logic                        last_result
);

	// accepted transaction occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after accepted transaction");

	// expired events are never the final result
	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result_kind == stq_pkg::KIND_EXPIRED) |-> !last_result)
		else $error("expired result flagged last");

	// every other result closes its transaction
	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result_kind != stq_pkg::KIND_EXPIRED) |-> last_result)
		else $error("non-expired result not flagged last");

	// no result right after the final one
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_result |=> !done)
		else $error("result directly after final result");

endmodule

bind sorted_timer_event_queue stq_checker u_stq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.result_kind (result_kind),
	.last_result (last_result)
);
